FILE: sv/rdpq_pkg.sv
// Shared types and constants for the RGB dither pen quantizer.
// No dependencies; the top level and rdpq_err_chan import it.
package rdpq_pkg;

    typedef enum logic [1:0] {
        ACT_PIXEL    = 2'd0,
        ACT_MAP_LOAD = 2'd1,
        ACT_PAL_LOAD = 2'd2
    } action_t;

    localparam logic [2:0] QUAL_OFF  = 3'd0;
    localparam logic [2:0] QUAL_FULL = 3'd4;

    typedef struct packed {
        logic dith;
        logic clear;
        logic acc;
        logic adv_b;
        logic wb;
    } err_ctl_t;

    // The 3-3-2 index: red 7:5 to bits 5:3, green 7:5 to bits 2:0, blue 7:6 to bits 7:6.
    function automatic logic [7:0] make_index(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        make_index = {b[7:6], r[7:5], g[7:5]};
    endfunction

endpackage

FILE: sv/rdpq_ifs.sv
// Valid/ready channel interfaces of the RGB dither pen quantizer.
// No dependencies.
interface rdpq_pix_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       line_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_index;
    logic [7:0] map_pen;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;

    modport source (output valid, action, line_start, red, green, blue, entry_index,
                    map_pen, pal_red, pal_green, pal_blue, input ready);
    modport sink (input valid, action, line_start, red, green, blue, entry_index,
                  map_pen, pal_red, pal_green, pal_blue, output ready);
endinterface

interface rdpq_pen_if;
    logic       valid;
    logic       ready;
    logic [7:0] pen;

    modport source (output valid, pen, input ready);
    modport sink (input valid, pen, output ready);
endinterface

interface rdpq_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] dither_quality;

    modport source (output valid, dither_quality, input ready);
    modport sink (input valid, dither_quality, output ready);
endinterface

FILE: sv/rgb_dither_pen_quantizer_unit.sv
// Top level of the RGB dither pen quantizer: color map and palette memories,
// pixel pipeline and output register. Depends on rdpq_pkg, rdpq_ifs and rdpq_err_chan.
//
// Usage: items arrive on the pix channel; each transfer is a pixel, a color map load
// or a palette load. Every pixel gives one transfer on the res channel carrying its
// pen; loads and the unused action give none. The cfg channel writes the dither
// quality and is always ready; write it only while the block is idle.
// A pixel's pen passes the map read, palette read and output registers to res.
// Throughput: loads and pixels at quality zero are taken one per cycle while res is not
// stalled. A dithered pixel's error update waits on the color map read and then the
// palette read, each a synchronous memory access, and the next item is held off
// until that update is written.
// Reset clears the quality, the running errors and all pipeline valid flags; the
// memories keep their contents and must be loaded before use.
// When res is stalled the whole pipeline and its memory reads freeze, and pix
// ready drops once the output register is full and not being taken.
module rgb_dither_pen_quantizer_unit #(
    parameter int ERROR_WIDTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    rdpq_cfg_if.sink   cfg,
    rdpq_pix_if.sink   pix,
    rdpq_pen_if.source res
);
    import rdpq_pkg::*;

    logic [7:0]  color_map [256];
    logic [23:0] palette [256];

    logic [2:0]  qual_reg, qual_next;
    logic        b_vld_reg, b_vld_next;
    logic        b_dith_reg, b_dith_next;
    logic        c_vld_reg, c_vld_next;
    logic        c_dith_reg, c_dith_next;
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  map_rd_reg;
    logic [23:0] pal_rd_reg;
    logic [7:0]  c_pen_reg;
    logic [7:0]  out_pen_reg;

    logic        dith_en;
    logic [1:0]  shift;
    logic        adv;
    logic        busy;
    logic        acc;
    logic        acc_pix;
    logic [7:0]  idx_r, idx_g, idx_b;
    logic [7:0]  map_addr;
    err_ctl_t    err_ctl;

    assign dith_en  = (qual_reg != QUAL_OFF);
    assign shift    = (qual_reg >= QUAL_FULL) ? 2'd0 : 2'(QUAL_FULL - qual_reg);
    assign adv      = !out_vld_reg || res.ready;
    assign busy     = (b_vld_reg && b_dith_reg) || (c_vld_reg && c_dith_reg);
    assign pix.ready = adv && !busy;
    assign acc      = pix.valid && pix.ready;
    assign acc_pix  = acc && (pix.action == ACT_PIXEL);
    assign cfg.ready = 1'b1;
    assign res.valid = out_vld_reg;
    assign res.pen   = out_pen_reg;

    assign err_ctl.dith  = dith_en;
    assign err_ctl.clear = acc && pix.line_start;
    assign err_ctl.acc   = acc_pix && dith_en;
    assign err_ctl.adv_b = adv && b_vld_reg;
    assign err_ctl.wb    = adv && c_vld_reg && c_dith_reg;

    rdpq_err_chan #(.ERROR_WIDTH(ERROR_WIDTH)) u_err_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (err_ctl),
        .shift   (shift),
        .sample  (pix.red),
        .pal_val (pal_rd_reg[23:16]),
        .idx_val (idx_r)
    );

    rdpq_err_chan #(.ERROR_WIDTH(ERROR_WIDTH)) u_err_g (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (err_ctl),
        .shift   (shift),
        .sample  (pix.green),
        .pal_val (pal_rd_reg[15:8]),
        .idx_val (idx_g)
    );

    rdpq_err_chan #(.ERROR_WIDTH(ERROR_WIDTH)) u_err_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (err_ctl),
        .shift   (shift),
        .sample  (pix.blue),
        .pal_val (pal_rd_reg[7:0]),
        .idx_val (idx_b)
    );

    assign map_addr = make_index(idx_r, idx_g, idx_b);

    // A palette load in the same cycle as a pixel's palette read is a nonblocking write,
    // so the read returns the old entry.
    always_ff @(posedge clk)
    begin
        if (acc && (pix.action == ACT_MAP_LOAD))
        begin
            color_map[pix.entry_index] <= pix.map_pen;
        end
        if (acc_pix)
        begin
            map_rd_reg <= color_map[map_addr];
        end
        if (acc && (pix.action == ACT_PAL_LOAD))
        begin
            palette[pix.entry_index] <= {pix.pal_red, pix.pal_green, pix.pal_blue};
        end
        if (adv && b_vld_reg)
        begin
            pal_rd_reg <= palette[map_rd_reg];
            c_pen_reg  <= map_rd_reg;
        end
        if (adv && c_vld_reg)
        begin
            out_pen_reg <= c_pen_reg;
        end
    end

    always_comb
    begin
        qual_next    = cfg.valid ? cfg.dither_quality : qual_reg;
        b_vld_next   = b_vld_reg;
        b_dith_next  = b_dith_reg;
        c_vld_next   = c_vld_reg;
        c_dith_next  = c_dith_reg;
        out_vld_next = out_vld_reg;
        if (adv)
        begin
            b_vld_next   = acc_pix;
            b_dith_next  = acc_pix && dith_en;
            c_vld_next   = b_vld_reg;
            c_dith_next  = b_vld_reg && b_dith_reg;
            out_vld_next = c_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qual_reg    <= QUAL_OFF;
            b_vld_reg   <= 1'b0;
            b_dith_reg  <= 1'b0;
            c_vld_reg   <= 1'b0;
            c_dith_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            qual_reg    <= qual_next;
            b_vld_reg   <= b_vld_next;
            b_dith_reg  <= b_dith_next;
            c_vld_reg   <= c_vld_next;
            c_dith_reg  <= c_dith_next;
            out_vld_reg <= out_vld_next;
        end
    end

`ifndef SYNTHESIS
    a_dith_no_follower: assert property (@(posedge clk) disable iff (!rst_n)
        (c_vld_reg && c_dith_reg) |-> !b_vld_reg)
        else $error("pixel entered behind a dithered pixel");

    a_wb_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_ctl.wb && err_ctl.clear))
        else $error("error write-back collided with a line start");

    a_pix_reaches_c: assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg && adv) |=> c_vld_reg)
        else $error("pixel lost between map read and palette read");

    a_res_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(c_vld_reg))
        else $error("result appeared without a pixel in the last stage");
`endif

endmodule

FILE: sv/rdpq_err_chan.sv
// One color channel of the error diffusion: running error, feedback sum and update.
// Depends on rdpq_pkg.
module rdpq_err_chan #(
    parameter int ERROR_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdpq_pkg::err_ctl_t ctl,
    input  logic [1:0]         shift,
    input  logic [7:0]         sample,
    input  logic [7:0]         pal_val,
    output logic [7:0]         idx_val
);
    import rdpq_pkg::*;

    localparam int EW = ERROR_WIDTH;
    localparam logic [EW-1:0] ERR_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] ERR_MIN = {1'b1, {(EW-1){1'b0}}};

    logic [EW-1:0] err_reg, err_next;
    logic [EW-1:0] sum_b_reg;
    logic [EW-1:0] sum_c_reg;
    logic [EW-1:0] err_cur;
    logic [EW-1:0] shifted;
    logic [EW:0]   sum_wide;
    logic [EW-1:0] sum_sat;
    logic [EW:0]   diff_wide;
    logic [EW-1:0] diff_sat;
    logic [7:0]    clip;

    always_comb
    begin
        err_cur  = ctl.clear ? '0 : err_reg;
        shifted  = EW'($signed(err_cur) >>> shift);
        sum_wide = {shifted[EW-1], shifted} + {{(EW-7){1'b0}}, sample};
        if (sum_wide[EW] != sum_wide[EW-1])
        begin
            sum_sat = sum_wide[EW] ? ERR_MIN : ERR_MAX;
        end
        else
        begin
            sum_sat = sum_wide[EW-1:0];
        end

        if (sum_sat[EW-1])
        begin
            clip = 8'd0;
        end
        else if (|sum_sat[EW-2:8])
        begin
            clip = 8'hff;
        end
        else
        begin
            clip = sum_sat[7:0];
        end
        idx_val = ctl.dith ? clip : sample;

        diff_wide = {sum_c_reg[EW-1], sum_c_reg} - {{(EW-7){1'b0}}, pal_val};
        if (diff_wide[EW] != diff_wide[EW-1])
        begin
            diff_sat = diff_wide[EW] ? ERR_MIN : ERR_MAX;
        end
        else
        begin
            diff_sat = diff_wide[EW-1:0];
        end

        err_next = err_reg;
        if (ctl.wb)
        begin
            err_next = diff_sat;
        end
        else if (ctl.clear)
        begin
            err_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
        end
        else
        begin
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc)
        begin
            sum_b_reg <= sum_sat;
        end
        if (ctl.adv_b)
        begin
            sum_c_reg <= sum_b_reg;
        end
    end

endmodule
